### design/prt_pkg.sv
// ----------------------------------------------------------------------------
// Packet id route table package
// Shared widths, operation and status codes, and controller/datapath types.
// ----------------------------------------------------------------------------
`default_nettype none

package prt_pkg;

   // Defaults for the top-level parameters.
   localparam int ENTRIES_DEF   = 16;
   localparam int ID_LIMIT_DEF  = 2047;
   localparam int DEST_BITS_DEF = 8;

   // Fixed field widths of the item channels.
   localparam int KIND_W     = 2;
   localparam int APP_ID_W   = 16;
   localparam int TAG_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   // Operation carried by an input item.
   typedef enum logic [KIND_W-1:0] {
      KIND_REGISTER   = 2'd0,
      KIND_UNREGISTER = 2'd1,
      KIND_ROUTE      = 2'd2,
      KIND_RESERVED   = 2'd3
   } kind_type;

   // Outcome reported with every result item.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Controller states.
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // take the input item and register the compare result
      logic commit;    // write back the table and load the result register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_stall; // result register holds an item that is not taken
   } stat_type;

endpackage : prt_pkg

`default_nettype wire

### design/packet_id_route_table_unit.sv
// Result: the item is captured on acceptance in the idle state, and the result register is
// loaded from the execute state once the downstream side no longer holds it.
// One item is in work at a time: the compare over all slots, registered at acceptance, is
// followed by the write-back into the slot array, which waits while the result is held.
// Reset: synchronous; clears all slot valid bits and the result valid bit,
// with no clearing pass.
// ----------------------------------------------------------------------------
// Packet id route table unit
// Associative table mapping application ids to destination tags.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_id_route_table_unit
   import prt_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int ID_LIMIT  = ID_LIMIT_DEF,
   parameter int DEST_BITS = DEST_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [KIND_W-1:0]     req_tuser,  // [1:0] kind
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // [15:0] app_id, [23:16] dest_tag
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata   // [1:0] status, [9:2] route_dest, zero pad
);

   cmd_type               cmd;
   stat_type              stat;
   logic [STATUS_W-1:0]   rsp_status;
   logic [TAG_W-1:0]      rsp_route_dest;

   // Sequencer.
   prt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Slot array and result register.
   prt_datapath #(
      .ENTRIES   (ENTRIES),
      .ID_LIMIT  (ID_LIMIT),
      .DEST_BITS (DEST_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_kind       (req_tuser),
      .req_app_id     (req_tdata[APP_ID_W-1:0]),
      .req_dest_tag   (req_tdata[APP_ID_W+TAG_W-1:APP_ID_W]),
      .rsp_tready     (rsp_tready),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_status     (rsp_status),
      .rsp_route_dest (rsp_route_dest)
   );

   // Pack the result item.
   assign rsp_tdata = {{(RSP_DATA_W-STATUS_W-TAG_W){1'b0}}, rsp_route_dest, rsp_status};

endmodule : packet_id_route_table_unit

`default_nettype wire

### design/prt_ctrl.sv
// ----------------------------------------------------------------------------
// Packet id route table controller
// Two-state sequencer: accept and compare, then write back and respond.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_ctrl
   import prt_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      req_tready  = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         S_EXEC: begin
            cmd.commit = !stat.rsp_stall;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule : prt_ctrl

`default_nettype wire

### design/prt_datapath.sv
// ----------------------------------------------------------------------------
// Packet id route table datapath
// Slot array with parallel id compare, free-slot encoder and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_datapath
   import prt_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEF,
   parameter int ID_LIMIT  = ID_LIMIT_DEF,
   parameter int DEST_BITS = DEST_BITS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output stat_type                   stat,
   input  wire logic [KIND_W-1:0]     req_kind,
   input  wire logic [APP_ID_W-1:0]   req_app_id,
   input  wire logic [TAG_W-1:0]      req_dest_tag,
   input  wire logic                  rsp_tready,
   output logic                       rsp_tvalid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [TAG_W-1:0]           rsp_route_dest
);

   localparam int ID_BITS = $clog2(ID_LIMIT + 1);

   // Slot storage: valid bits are reset, ids and tags are not.
   logic [ENTRIES-1:0]   slot_valid_ff;
   logic [ENTRIES-1:0]   slot_valid_in;
   logic [ID_BITS-1:0]   slot_id_ff   [ENTRIES];
   logic [DEST_BITS-1:0] slot_dest_ff [ENTRIES];

   // Item captured at acceptance.
   kind_type             kind_ff;
   logic                 id_ok_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [DEST_BITS-1:0] tag_ff;
   logic [ENTRIES-1:0]   hit_ff;

   logic [ENTRIES-1:0]   hit_in;
   logic [DEST_BITS-1:0] tag_in;
   logic [DEST_BITS+TAG_W-1:0] tag_wide;

   // Result register.
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           rsp_status_ff;
   status_type           rsp_status_in;
   logic [TAG_W-1:0]     rsp_dest_ff;
   logic [TAG_W-1:0]     rsp_dest_in;

   // Write-back selection.
   logic [ENTRIES-1:0]   free_vec;
   logic [ENTRIES-1:0]   free_onehot;
   logic [ENTRIES-1:0]   write_sel;
   logic                 hit_any;
   logic [DEST_BITS-1:0] hit_dest;
   logic [DEST_BITS+TAG_W-1:0] dest_wide;

   // Stored tags keep the low DEST_BITS bits of the input tag.
   assign tag_wide = {{DEST_BITS{1'b0}}, req_dest_tag};
   assign tag_in   = tag_wide[DEST_BITS-1:0];

   // Parallel compare of the incoming id against every valid slot.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         hit_in[i] = slot_valid_ff[i] && (slot_id_ff[i] == req_app_id[ID_BITS-1:0]);
      end
   end

   // Capture the item and its compare vector.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind_type'(req_kind);
         id_ok_ff <= (req_app_id <= APP_ID_W'(ID_LIMIT));
         id_ff    <= req_app_id[ID_BITS-1:0];
         tag_ff   <= tag_in;
         hit_ff   <= hit_in;
      end
   end

   // Lowest free slot as a one-hot vector.
   assign free_vec    = ~slot_valid_ff;
   assign free_onehot = free_vec & (~free_vec + ENTRIES'(1));
   assign hit_any     = |hit_ff;

   // Tag of the matching slot; ids are unique among valid slots.
   always_comb begin
      hit_dest = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (hit_ff[i]) begin
            hit_dest = hit_dest | slot_dest_ff[i];
         end
      end
   end

   assign dest_wide = {{TAG_W{1'b0}}, hit_dest};

   // Operation decode for the write-back cycle.
   always_comb begin
      slot_valid_in = slot_valid_ff;
      write_sel     = '0;
      rsp_status_in = ST_NOT_FOUND;
      rsp_dest_in   = '0;
      if (!id_ok_ff) begin
         rsp_status_in = ST_INVALID;
      end else begin
         case (kind_ff)
            KIND_REGISTER: begin
               write_sel = hit_any ? hit_ff : free_onehot;
               if (write_sel == '0) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  slot_valid_in = slot_valid_ff | write_sel;
                  rsp_status_in = ST_OK;
               end
            end
            KIND_UNREGISTER: begin
               if (hit_any) begin
                  slot_valid_in = slot_valid_ff & ~hit_ff;
                  rsp_status_in = ST_OK;
               end
            end
            KIND_ROUTE: begin
               if (hit_any) begin
                  rsp_dest_in   = dest_wide[TAG_W-1:0];
                  rsp_status_in = ST_OK;
               end
            end
            default: begin
               rsp_status_in = ST_NOT_FOUND;
            end
         endcase
      end
   end

   // Valid bits, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (cmd.commit) begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   // Slot id and tag write-back.
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (cmd.commit && write_sel[i]) begin
            slot_id_ff[i]   <= id_ff;
            slot_dest_ff[i] <= tag_ff;
         end
      end
   end

   // Result register handshake.
   assign rsp_valid_in = cmd.commit ? 1'b1 : (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_dest_ff   <= rsp_dest_in;
      end
   end

   assign stat.rsp_stall = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_route_dest = rsp_dest_ff;

endmodule : prt_datapath

`default_nettype wire

### design/prt_checker.sv
// ----------------------------------------------------------------------------
// Packet id route table checker
// Port-level properties of the route table unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prt_checker
   import prt_pkg::*;
#(
   parameter int ID_LIMIT = ID_LIMIT_DEF
)
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic [REQ_DATA_W-1:0] req_tdata,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_acc;
   logic req_bad_id;

   assign req_acc    = req_tvalid && req_tready;
   assign req_bad_id = req_tdata[APP_ID_W-1:0] > APP_ID_W'(ID_LIMIT);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Only one item is in work: no acceptance in the cycle after one.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("item accepted while previous item in work");

   // A destination is reported only with an ok status.
   a_dest_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[STATUS_W-1:0] != ST_OK) |->
         rsp_tdata[STATUS_W+TAG_W-1:STATUS_W] == '0)
      else $error("route_dest nonzero without ok status");

   // An out-of-range id accepted while the output is free is reported as rejected
   // once it is written back from the execute state.
   a_bad_id: assert property (@(posedge clock) disable iff (reset)
      req_acc && req_bad_id && !rsp_tvalid |-> ##2
         (rsp_tvalid && (rsp_tdata[STATUS_W-1:0] == ST_INVALID)))
      else $error("invalid id not reported");

endmodule : prt_checker

bind packet_id_route_table_unit prt_checker #(
   .ID_LIMIT (ID_LIMIT)
) u_prt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
